FILE: hdl/ct_pkg.sv
// types and constants shared by the connection table engine
package ct_pkg;

  localparam int SLOTS = 8;
  localparam int SW    = $clog2(SLOTS);
  localparam int CMPW  = SW + 3;

  localparam logic [5:0] LIMIT_RESET = 6'd24;

  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_DPORT  = 2'd2,
    OP_CLOSE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_CLOSED   = 2'd3
  } status_e;

  // request travelling down the row of slot cells
  typedef struct packed {
    logic          valid;
    op_e           op;
    logic          ctype;
    logic [5:0]    dport;
    logic [5:0]    sport;
    logic [13:0]   node;
    logic [2:0]    idx;
    logic [SW-1:0] last;
    logic          found;
    logic [SW-1:0] hit_idx;
    logic [5:0]    hit_port;
    logic          any_ok;
    logic [SW-1:0] any_idx;
    logic          aft_ok;
    logic [SW-1:0] aft_idx;
  } tok_t;

  // state update broadcast to the cells at the end of a pass
  typedef struct packed {
    logic          alloc;
    logic          close;
    logic [SW-1:0] idx;
    logic          server;
    logic [5:0]    dport;
    logic [5:0]    sport;
    logic [13:0]   node;
  } commit_t;

endpackage

FILE: hdl/ct_cell.sv
// one connection slot: holds its entry and checks the passing request
module ct_cell import ct_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [SW-1:0] cell_idx_i,
  input  tok_t          tok_i,
  input  commit_t       commit_i,
  output tok_t          tok_o
);

  logic        open_q, open_d;
  logic        server_q;
  logic [5:0]  dport_q;
  logic [5:0]  sport_q;
  logic [13:0] node_q;
  logic        tok_valid_q;
  tok_t        tok_d, tok_q;
  logic        mine;
  logic        match;

  assign mine = (commit_i.alloc || commit_i.close) && (commit_i.idx == cell_idx_i);

  always_comb begin
    open_d = open_q;
    if (mine) begin
      open_d = commit_i.alloc;
    end
  end

  always_comb begin
    match = 1'b0;
    if (open_q && (dport_q == tok_i.dport)) begin
      if (tok_i.op == OP_DPORT) begin
        match = !server_q;
      end else begin
        match = !server_q || ((sport_q == tok_i.sport) && (node_q == tok_i.node));
      end
    end
  end

  always_comb begin
    tok_d = tok_i;
    unique case (tok_i.op)
      OP_ALLOC: begin
        if (!open_q) begin
          if (!tok_i.any_ok) begin
            tok_d.any_ok  = 1'b1;
            tok_d.any_idx = cell_idx_i;
          end
          if (!tok_i.aft_ok && (cell_idx_i > tok_i.last)) begin
            tok_d.aft_ok  = 1'b1;
            tok_d.aft_idx = cell_idx_i;
          end
        end
      end
      OP_LOOKUP, OP_DPORT: begin
        if (!tok_i.found && match) begin
          tok_d.found    = 1'b1;
          tok_d.hit_idx  = cell_idx_i;
          tok_d.hit_port = dport_q;
        end
      end
      OP_CLOSE: begin
        if (CMPW'(tok_i.idx) == CMPW'(cell_idx_i)) begin
          tok_d.found    = open_q;
          tok_d.hit_idx  = cell_idx_i;
          tok_d.hit_port = dport_q;
        end
      end
      default: begin
        tok_d = tok_i;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q      <= 1'b0;
      tok_valid_q <= 1'b0;
    end else begin
      open_q      <= open_d;
      tok_valid_q <= tok_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q <= tok_d;
    if (mine && commit_i.alloc) begin
      server_q <= commit_i.server;
      dport_q  <= commit_i.dport;
      sport_q  <= commit_i.sport;
      node_q   <= commit_i.node;
    end
  end

  always_comb begin
    tok_o       = tok_q;
    tok_o.valid = tok_valid_q;
  end

endmodule

FILE: hdl/connection_table_engine_top.sv
// connection table engine: a request walks the row of slot cells, one cell a cycle
// the request is registered at the input, in every slot cell and again at the result
// a new start is not taken while busy, that is until the request has left the last cell
// reset: every slot closed, round robin pointer at slot 0, port limit 24
// the result strobe lasts one cycle and the receiver cannot stall it
module connection_table_engine_top import ct_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  opcode_i,
  input  logic        conn_type_i,
  input  logic [5:0]  dest_port_i,
  input  logic [5:0]  source_port_i,
  input  logic [13:0] source_node_i,
  input  logic [2:0]  slot_index_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [2:0]  slot_o,
  output logic [5:0]  local_port_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [5:0]  cfg_data_i
);

  tok_t          tok_w [SLOTS+1];
  tok_t          tok0_q, tok0_d;
  logic          tok0_valid_q;
  logic          busy_q, busy_d;
  logic [5:0]    limit_q;
  logic [SW-1:0] last_q, last_d;
  logic          accept;
  tok_t          fin;
  commit_t       commit;
  logic          done_q;
  status_e       status_q, status_d;
  logic [SW-1:0] slot_q, slot_d;
  logic [5:0]    port_q, port_d;
  logic [SW-1:0] sel;
  logic          idx_ok;

  assign accept      = start && !busy_q;
  assign busy        = busy_q;
  assign cfg_ready_o = !busy_q;

  always_comb begin
    tok_w[0]       = tok0_q;
    tok_w[0].valid = tok0_valid_q;
  end

  for (genvar k = 0; k < SLOTS; k++) begin : g_cell
    ct_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cell_idx_i(SW'(k)),
      .tok_i     (tok_w[k]),
      .commit_i  (commit),
      .tok_o     (tok_w[k+1])
    );
  end

  assign fin    = tok_w[SLOTS];
  assign idx_ok = CMPW'(fin.idx) < CMPW'(SLOTS);
  assign sel    = fin.aft_ok ? fin.aft_idx : fin.any_idx;

  always_comb begin
    status_d = ST_NOTFOUND;
    slot_d   = '0;
    port_d   = '0;
    last_d   = last_q;
    commit   = '0;
    if (fin.valid) begin
      unique case (fin.op)
        OP_ALLOC: begin
          if (fin.any_ok) begin
            status_d      = ST_OK;
            slot_d        = sel;
            port_d        = fin.ctype ? fin.dport : 6'(limit_q + 6'd1 + 6'(sel));
            last_d        = sel;
            commit.alloc  = 1'b1;
            commit.idx    = sel;
            commit.server = fin.ctype;
            commit.dport  = port_d;
            commit.sport  = fin.sport;
            commit.node   = fin.node;
          end else begin
            status_d = ST_FULL;
          end
        end
        OP_LOOKUP, OP_DPORT: begin
          if (fin.found) begin
            status_d = ST_OK;
            slot_d   = fin.hit_idx;
            port_d   = fin.hit_port;
          end
        end
        OP_CLOSE: begin
          if (idx_ok) begin
            slot_d = fin.hit_idx;
            if (fin.found) begin
              status_d     = ST_OK;
              port_d       = fin.hit_port;
              commit.close = 1'b1;
              commit.idx   = fin.hit_idx;
            end else begin
              status_d = ST_CLOSED;
            end
          end
        end
        default: begin
          status_d = ST_NOTFOUND;
        end
      endcase
    end
  end

  always_comb begin
    busy_d = busy_q;
    if (accept) begin
      busy_d = 1'b1;
    end else if (fin.valid) begin
      busy_d = 1'b0;
    end
  end

  always_comb begin
    tok0_d       = '0;
    tok0_d.op    = op_e'(opcode_i);
    tok0_d.ctype = conn_type_i;
    tok0_d.dport = dest_port_i;
    tok0_d.sport = source_port_i;
    tok0_d.node  = source_node_i;
    tok0_d.idx   = slot_index_i;
    tok0_d.last  = last_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q       <= 1'b0;
      tok0_valid_q <= 1'b0;
      done_q       <= 1'b0;
      last_q       <= '0;
      limit_q      <= LIMIT_RESET;
    end else begin
      busy_q       <= busy_d;
      tok0_valid_q <= accept;
      done_q       <= fin.valid;
      last_q       <= last_d;
      if (cfg_valid_i && cfg_ready_o) begin
        limit_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      tok0_q <= tok0_d;
    end
    if (fin.valid) begin
      status_q <= status_d;
      slot_q   <= slot_d;
      port_q   <= port_d;
    end
  end

  assign done_o       = done_q;
  assign status_o     = status_q;
  assign slot_o       = 3'(slot_q);
  assign local_port_o = port_q;

endmodule

FILE: hdl/ct_checker.sv
// port level checks for the connection table engine
module ct_checker import ct_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic       done_o,
  input logic [1:0] status_o,
  input logic [2:0] slot_o,
  input logic [5:0] local_port_o,
  input logic       cfg_ready_o
);

  // an accepted item holds the engine busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("busy not raised after accepted item");

  // busy ends exactly when the result is shown
  a_fall_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("busy dropped without a result");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy && cfg_ready_o)
    else $error("result shown while busy");

  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result repeated");

  a_full_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o == ST_FULL || status_o == ST_NOTFOUND) |->
      slot_o == 3'd0 && local_port_o == 6'd0)
    else $error("failed item carries slot data");

endmodule

bind connection_table_engine_top ct_checker u_ct_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .done_o      (done_o),
  .status_o    (status_o),
  .slot_o      (slot_o),
  .local_port_o(local_port_o),
  .cfg_ready_o (cfg_ready_o)
);
